[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/upa_pkg.sv]
// ----------------------------------------------------------------------------
// upa_pkg
// Shared types and constants of the absolute path parser
// ----------------------------------------------------------------------------
package upa_pkg;

	// counter width for byte positions and segment lengths
	localparam int LEN_BITS = 16;

	// command queue between front and back
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	// result queue on the output side
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);
	localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

	// byte classes seen by the parser
	typedef enum logic [2:0] {
		CLS_SLASH,
		CLS_PCT,
		CLS_HEX,
		CLS_PCHAR,
		CLS_STOP
	} byte_class_t;

	// final report status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_TRUNC     = 3'd3,
		ST_TOOLONG   = 3'd4
	} status_t;

	// classified word handed from front to back
	typedef struct packed {
		byte_class_t cls;
		logic        is_last;
		logic        buffer_empty;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic                kind;
		logic [LEN_BITS-1:0] seg_offset;
		logic [LEN_BITS-1:0] seg_length;
		status_t             status;
		logic [LEN_BITS-1:0] consumed;
		logic                last_result;
	} result_t;

endpackage

[src/upa_front.sv]
// ----------------------------------------------------------------------------
// upa_front
// Accepts path bytes, classifies them and queues the classified words
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upa_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      data_byte,
	input  logic            is_last,
	input  logic            buffer_empty,
	output logic            cmd_valid,
	output upa_pkg::cmd_t   cmd,
	input  logic            cmd_take
);

	upa_pkg::byte_class_t            cls;
	upa_pkg::cmd_t                   cq_mem [upa_pkg::CQ_DEPTH];
	logic [upa_pkg::CQ_AW-1:0]       wp_q;
	logic [upa_pkg::CQ_AW-1:0]       rp_q;
	logic [upa_pkg::CQ_CW-1:0]       count_q;
	logic                            wr_en;
	logic                            rd_en;

	// byte classification against the pchar and hex sets
	always_comb begin
		cls = upa_pkg::CLS_STOP;
		if (data_byte == 8'h2F) begin
			cls = upa_pkg::CLS_SLASH;
		end else if (data_byte == 8'h25) begin
			cls = upa_pkg::CLS_PCT;
		end else if (data_byte inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]}) begin
			cls = upa_pkg::CLS_HEX;
		end else if (data_byte inside {[8'h41:8'h5A], [8'h61:8'h7A], 8'h2D, 8'h2E, 8'h5F,
				8'h7E, 8'h21, 8'h24, [8'h26:8'h2C], 8'h3B, 8'h3D, 8'h3A, 8'h40}) begin
			cls = upa_pkg::CLS_PCHAR;
		end
	end

	assign full      = (count_q == upa_pkg::CQ_CW'(upa_pkg::CQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;
	assign cmd       = cq_mem[rp_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_mem[wp_q] <= '{cls: cls, is_last: is_last, buffer_empty: buffer_empty};
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + upa_pkg::CQ_CW'(wr_en) - upa_pkg::CQ_CW'(rd_en);
		end
	end

	`ASSERT_ALWAYS(a_cq_bound, clk, arst_n, count_q <= upa_pkg::CQ_CW'(upa_pkg::CQ_DEPTH))
	`ASSERT_NEXT(a_cq_hold, clk, arst_n, full && !rd_en, $stable(count_q) && $stable(wp_q))

endmodule

[src/upa_back.sv]
// ----------------------------------------------------------------------------
// upa_back
// Path grammar state machine and the result queue
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module upa_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  upa_pkg::cmd_t       cmd,
	output logic                cmd_take,
	output logic                empty,
	input  logic                pop,
	output upa_pkg::result_t    res
);

	typedef enum logic [2:0] {
		M_START,
		M_SEG,
		M_ESC1,
		M_ESC2,
		M_SKIP
	} mode_t;

	mode_t                               mode_q, mode_n;
	logic [upa_pkg::LEN_BITS-1:0]        pos_q, pos_n;
	logic [upa_pkg::LEN_BITS-1:0]        start_q, start_n;
	logic [upa_pkg::LEN_BITS-1:0]        len_q, len_n;
	logic                                fin;
	upa_pkg::status_t                    fin_st;
	logic                                fin_last;
	logic                                seg_emit;
	logic                                room;
	logic                                hex;
	logic                                consume;
	upa_pkg::result_t                    seg_rec;
	upa_pkg::result_t                    fin_rec;
	upa_pkg::result_t                    w0;
	upa_pkg::result_t                    rq_mem [upa_pkg::RQ_DEPTH];
	logic [upa_pkg::RQ_AW-1:0]           wp_q;
	logic [upa_pkg::RQ_AW-1:0]           rp_q;
	logic [upa_pkg::RQ_CW-1:0]           count_q;
	logic [1:0]                          nw;
	logic                                rd_en;

	// take a word only when two result slots are free
	assign cmd_take = cmd_valid && (count_q <= upa_pkg::RQ_CW'(upa_pkg::RQ_DEPTH - 2));
	assign room     = (pos_q != '1);
	assign hex      = (cmd.cls == upa_pkg::CLS_HEX);
	assign consume  = (cmd.cls == upa_pkg::CLS_SLASH) || (cmd.cls == upa_pkg::CLS_PCT)
		|| (cmd.cls == upa_pkg::CLS_HEX) || (cmd.cls == upa_pkg::CLS_PCHAR);

	// grammar step
	always_comb begin
		mode_n   = mode_q;
		pos_n    = pos_q;
		start_n  = start_q;
		len_n    = len_q;
		fin      = 1'b0;
		fin_st   = upa_pkg::ST_OK;
		fin_last = cmd.is_last;
		seg_emit = 1'b0;
		if (cmd.buffer_empty) begin
			fin_last = 1'b1;
			case (mode_q)
				M_START: begin
					fin    = 1'b1;
					fin_st = upa_pkg::ST_EMPTY;
				end
				M_SEG: begin
					fin = 1'b1;
				end
				M_ESC1, M_ESC2: begin
					fin    = 1'b1;
					fin_st = upa_pkg::ST_TRUNC;
				end
				default: begin
					mode_n = M_START;
				end
			endcase
		end else begin
			case (mode_q)
				M_START: begin
					if (cmd.cls != upa_pkg::CLS_SLASH) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_MALFORMED;
					end else begin
						pos_n   = upa_pkg::LEN_BITS'(1);
						start_n = upa_pkg::LEN_BITS'(1);
						len_n   = '0;
						mode_n  = M_SEG;
						fin     = cmd.is_last;
					end
				end
				M_SEG: begin
					if (!consume) begin
						fin = 1'b1;
					end else if (!room) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_TOOLONG;
					end else if (cmd.cls == upa_pkg::CLS_SLASH) begin
						seg_emit = 1'b1;
						pos_n    = pos_q + 1'b1;
						start_n  = pos_q + 1'b1;
						len_n    = '0;
						fin      = cmd.is_last;
					end else if (cmd.cls == upa_pkg::CLS_PCT) begin
						pos_n = pos_q + 1'b1;
						len_n = len_q + 1'b1;
						if (cmd.is_last) begin
							fin    = 1'b1;
							fin_st = upa_pkg::ST_TRUNC;
						end else begin
							mode_n = M_ESC1;
						end
					end else begin
						pos_n = pos_q + 1'b1;
						len_n = len_q + 1'b1;
						fin   = cmd.is_last;
					end
				end
				M_ESC1: begin
					if (cmd.is_last) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_TRUNC;
					end else if (!hex) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_MALFORMED;
					end else if (!room) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_TOOLONG;
					end else begin
						pos_n  = pos_q + 1'b1;
						len_n  = len_q + 1'b1;
						mode_n = M_ESC2;
					end
				end
				M_ESC2: begin
					if (!hex) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_MALFORMED;
					end else if (!room) begin
						fin    = 1'b1;
						fin_st = upa_pkg::ST_TOOLONG;
					end else begin
						pos_n  = pos_q + 1'b1;
						len_n  = len_q + 1'b1;
						mode_n = M_SEG;
						fin    = cmd.is_last;
					end
				end
				default: begin
					if (cmd.is_last) begin
						mode_n = M_START;
					end
				end
			endcase
		end
		if (fin) begin
			mode_n = fin_last ? M_START : M_SKIP;
		end
	end

	// result words for this step
	always_comb begin
		seg_rec = '{kind: 1'b0, seg_offset: start_q, seg_length: len_q,
			status: upa_pkg::ST_OK, consumed: '0, last_result: 1'b0};
		if (fin_st == upa_pkg::ST_OK) begin
			fin_rec = '{kind: 1'b1, seg_offset: start_n, seg_length: len_n,
				status: upa_pkg::ST_OK, consumed: pos_n, last_result: 1'b1};
		end else begin
			fin_rec = '{kind: 1'b1, seg_offset: '0, seg_length: '0,
				status: fin_st, consumed: '0, last_result: 1'b1};
		end
		w0 = seg_emit ? seg_rec : fin_rec;
		nw = cmd_take ? (2'(seg_emit) + 2'(fin)) : 2'd0;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_START;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
		end else if (cmd_take) begin
			mode_q  <= mode_n;
			pos_q   <= pos_n;
			start_q <= start_n;
			len_q   <= len_n;
		end
	end

	// result queue storage, up to two writes a cycle
	always_ff @(posedge clk) begin
		if (nw != 2'd0) begin
			rq_mem[wp_q] <= w0;
		end
		if (nw == 2'd2) begin
			rq_mem[wp_q + 1'b1] <= fin_rec;
		end
	end

	assign empty = (count_q == '0);
	assign rd_en = pop && !empty;
	assign res   = rq_mem[rp_q];

	// result queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + upa_pkg::RQ_AW'(nw);
			if (rd_en) begin
				rp_q <= rp_q + 1'b1;
			end
			count_q <= count_q + upa_pkg::RQ_CW'(nw) - upa_pkg::RQ_CW'(rd_en);
		end
	end

	`ASSERT_ALWAYS(a_rq_bound, clk, arst_n, count_q <= upa_pkg::RQ_CW'(upa_pkg::RQ_DEPTH))
	`ASSERT_NEXT(a_end_restart, clk, arst_n, cmd_take && fin && fin_last, mode_q == M_START)
	`ASSERT_NEXT(a_error_skip, clk, arst_n, cmd_take && fin && !fin_last, mode_q == M_SKIP)

endmodule

[src/uri_absolute_path_parser.sv]
// Results pass through the registered command and result queues. Throughput: one byte
// per cycle while two result slots are free, set by the single-step grammar in upa_back.
// A byte that closes a segment and ends the path makes two results, popped one at a time.
// Reset (arst_n low, asynchronous) empties both queues and returns the parser to
// waiting for the leading slash with all counters at zero.
// ----------------------------------------------------------------------------
// uri_absolute_path_parser
// Streaming checker for absolute URI paths with segment and final reports
// ----------------------------------------------------------------------------
module uri_absolute_path_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [7:0]                    data_byte,
	input  logic                          is_last,
	input  logic                          buffer_empty,
	output logic                          empty,
	input  logic                          pop,
	output logic                          kind,
	output logic [upa_pkg::LEN_BITS-1:0]  seg_offset,
	output logic [upa_pkg::LEN_BITS-1:0]  seg_length,
	output logic [2:0]                    status,
	output logic [upa_pkg::LEN_BITS-1:0]  consumed,
	output logic                          last_result
);

	logic              cmd_valid;
	upa_pkg::cmd_t     cmd;
	logic              cmd_take;
	upa_pkg::result_t  res;

	// byte intake and classification
	upa_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.buffer_empty (buffer_empty),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.cmd_take     (cmd_take)
	);

	// grammar machine and result queue
	upa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	// result word to ports
	assign kind        = res.kind;
	assign seg_offset  = res.seg_offset;
	assign seg_length  = res.seg_length;
	assign status      = res.status;
	assign consumed    = res.consumed;
	assign last_result = res.last_result;

endmodule

[dv/path_checker.sv]
// ----------------------------------------------------------------------------
// path_checker
// Watches both queue ports of the absolute path parser, predicts every result
// word from the accepted input words and compares them field by field.
// ----------------------------------------------------------------------------
module path_checker
	import upa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [7:0]          data_byte,
	input  logic                is_last,
	input  logic                buffer_empty,
	input  logic                empty,
	input  logic                pop,
	input  logic                kind,
	input  logic [LEN_BITS-1:0] seg_offset,
	input  logic [LEN_BITS-1:0] seg_length,
	input  logic [2:0]          status,
	input  logic [LEN_BITS-1:0] consumed,
	input  logic                last_result,
	input  logic                end_of_test,
	output int                  fail_count,
	output int                  pending
);

	localparam logic       KIND_SEGMENT = 1'b0;
	localparam logic       KIND_FINAL   = 1'b1;
	localparam logic [7:0] SLASH        = "/";
	localparam logic [7:0] PCT          = "%";
	localparam int         MAX_PRINTS   = 100;

	typedef enum logic [2:0] {
		AWAIT_SLASH,
		IN_SEGMENT,
		ESC_FIRST,
		ESC_SECOND,
		SKIP_REST
	} parse_state_t;

	// predicted parser state
	parse_state_t        pstate;
	logic [LEN_BITS-1:0] pos;
	logic [LEN_BITS-1:0] seg_start;
	logic [LEN_BITS-1:0] seg_len;
	result_t             expected_reports[$];
	bit                  leftovers_checked;

	function automatic bit is_hex_digit(logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
	endfunction

	// unreserved, sub-delims, ':' and '@'
	function automatic bit is_path_char(logic [7:0] b);
		if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
			return 1'b1;
		case (b)
			"-", ".", "_", "~", "!", "$", "&", "'", "(", ")",
			"*", "+", ",", ";", "=", ":", "@": return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		if (fail_count < MAX_PRINTS)
			$display("[%0t] path_checker: %s", $time, msg);
		fail_count++;
	endtask

	// final report; error reports carry no segment or count
	task automatic close_path(status_t st, logic last);
		result_t r;
		r = '0;
		r.kind = KIND_FINAL;
		r.status = st;
		r.last_result = 1'b1;
		if (st == ST_OK) begin
			r.seg_offset = seg_start;
			r.seg_length = seg_len;
			r.consumed = pos;
		end
		expected_reports.push_back(r);
		pstate = last ? AWAIT_SLASH : SKIP_REST;
	endtask

	// one step of the path grammar for an accepted input word
	task automatic parse_word(logic [7:0] b, logic last, logic emp);
		result_t seg;
		logic    room;
		room = (pos != {LEN_BITS{1'b1}});
		if (emp) begin
			case (pstate)
				AWAIT_SLASH: close_path(ST_EMPTY, 1'b1);
				IN_SEGMENT: close_path(ST_OK, 1'b1);
				ESC_FIRST, ESC_SECOND: close_path(ST_TRUNC, 1'b1);
				default: pstate = AWAIT_SLASH;
			endcase
		end else begin
			case (pstate)
				AWAIT_SLASH: begin
					if (b != SLASH) begin
						close_path(ST_MALFORMED, last);
					end else begin
						pos = LEN_BITS'(1);
						seg_start = LEN_BITS'(1);
						seg_len = '0;
						pstate = IN_SEGMENT;
						if (last)
							close_path(ST_OK, 1'b1);
					end
				end
				IN_SEGMENT: begin
					if (b != SLASH && b != PCT && !is_path_char(b)) begin
						// stop byte, not consumed
						close_path(ST_OK, last);
					end else if (!room) begin
						close_path(ST_TOOLONG, last);
					end else if (b == SLASH) begin
						seg = '0;
						seg.kind = KIND_SEGMENT;
						seg.seg_offset = seg_start;
						seg.seg_length = seg_len;
						seg.status = ST_OK;
						expected_reports.push_back(seg);
						pos++;
						seg_start = pos;
						seg_len = '0;
						if (last)
							close_path(ST_OK, 1'b1);
					end else begin
						pos++;
						seg_len++;
						if (b == PCT) begin
							if (last)
								close_path(ST_TRUNC, 1'b1);
							else
								pstate = ESC_FIRST;
						end else if (last) begin
							close_path(ST_OK, 1'b1);
						end
					end
				end
				ESC_FIRST: begin
					if (last) begin
						close_path(ST_TRUNC, 1'b1);
					end else if (!is_hex_digit(b)) begin
						close_path(ST_MALFORMED, 1'b0);
					end else if (!room) begin
						close_path(ST_TOOLONG, 1'b0);
					end else begin
						pos++;
						seg_len++;
						pstate = ESC_SECOND;
					end
				end
				ESC_SECOND: begin
					if (!is_hex_digit(b)) begin
						close_path(ST_MALFORMED, last);
					end else if (!room) begin
						close_path(ST_TOOLONG, last);
					end else begin
						pos++;
						seg_len++;
						pstate = IN_SEGMENT;
						if (last)
							close_path(ST_OK, 1'b1);
					end
				end
				default: begin
					if (last)
						pstate = AWAIT_SLASH;
				end
			endcase
		end
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// popped word against the oldest prediction
	task automatic compare_report();
		result_t want;
		if (expected_reports.size() == 0) begin
			report_mismatch("result word popped with no report expected");
		end else begin
			want = expected_reports.pop_front();
			check_field("kind", 32'(kind), 32'(want.kind));
			check_field("seg_offset", 32'(seg_offset), 32'(want.seg_offset));
			check_field("seg_length", 32'(seg_length), 32'(want.seg_length));
			check_field("status", 32'(status), 32'(want.status));
			check_field("consumed", 32'(consumed), 32'(want.consumed));
			check_field("last_result", 32'(last_result), 32'(want.last_result));
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pstate = AWAIT_SLASH;
			pos = '0;
			seg_start = '0;
			seg_len = '0;
			expected_reports.delete();
			leftovers_checked = 1'b0;
			pending <= 0;
		end else begin
			if (push && !full)
				parse_word(data_byte, is_last, buffer_empty);
			if (pop && !empty)
				compare_report();
			if (end_of_test && !leftovers_checked) begin
				leftovers_checked = 1'b1;
				if (expected_reports.size() != 0)
					report_mismatch($sformatf("%0d reports never arrived",
						expected_reports.size()));
			end
			pending <= expected_reports.size();
		end
	end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives byte words into the absolute path parser with random gaps and pops
// its results with random stalls; a separate checker predicts and compares.
// Directed corner paths come first, then random paths.
// ----------------------------------------------------------------------------
module tb_top;
	import upa_pkg::*;

	localparam int         RANDOM_WORDS = 1950;
	localparam int         IDLE_LIMIT   = 1000;
	localparam logic [7:0] SLASH        = "/";
	localparam logic [7:0] PCT          = "%";
	localparam string      PATH_CHARS   =
		"abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~!$&'()*+,;=:@";
	localparam string      HEX_CHARS    = "0123456789abcdefABCDEF";
	localparam string      NON_HEX      = "gGxzZ-._~!:@/%?#";
	localparam string      STOP_CHARS   = " ?#\"<>[]\\^`{|}";

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                push         = 1'b0;
	logic [7:0]          data_byte    = '0;
	logic                is_last      = 1'b0;
	logic                buffer_empty = 1'b0;
	logic                pop          = 1'b0;
	logic                full;
	logic                empty;
	logic                kind;
	logic [LEN_BITS-1:0] seg_offset;
	logic [LEN_BITS-1:0] seg_length;
	logic [2:0]          status;
	logic [LEN_BITS-1:0] consumed;
	logic                last_result;

	bit                  quiet        = 1'b0;
	bit                  end_of_test  = 1'b0;
	int                  fail_count;
	int                  pending;
	int                  words_sent   = 0;
	int                  pop_stall    = 0;
	int                  idle_cycles  = 0;

	uri_absolute_path_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.buffer_empty (buffer_empty),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.seg_offset   (seg_offset),
		.seg_length   (seg_length),
		.status       (status),
		.consumed     (consumed),
		.last_result  (last_result)
	);

	path_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.is_last      (is_last),
		.buffer_empty (buffer_empty),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.seg_offset   (seg_offset),
		.seg_length   (seg_length),
		.status       (status),
		.consumed     (consumed),
		.last_result  (last_result),
		.end_of_test  (end_of_test),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic [7:0] random_pchar();
		return PATH_CHARS[$urandom_range(0, PATH_CHARS.len() - 1)];
	endfunction

	function automatic logic [7:0] random_hex();
		return HEX_CHARS[$urandom_range(0, HEX_CHARS.len() - 1)];
	endfunction

	function automatic logic [7:0] random_non_hex();
		return NON_HEX[$urandom_range(0, NON_HEX.len() - 1)];
	endfunction

	function automatic logic [7:0] random_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// byte that ends a path without being consumed
	function automatic logic [7:0] random_stop();
		case ($urandom_range(0, 2))
			0: return STOP_CHARS[$urandom_range(0, STOP_CHARS.len() - 1)];
			1: return 8'($urandom_range(128, 255));
			default: return 8'($urandom_range(0, 32));
		endcase
	endfunction

	// result side: pop with random stalls after each accepted word
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
			pop_stall = 0;
		end else begin
			if (pop && !empty)
				pop_stall = pick_gap();
			if (pop_stall > 0) begin
				pop_stall--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// one input word, held until accepted
	task automatic push_word(logic [7:0] b, logic last, logic emp);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= b;
		is_last <= last;
		buffer_empty <= emp;
		@(posedge clk);
		while (full) @(posedge clk);
		words_sent++;
	endtask

	task automatic send_empty();
		push_word(random_byte(), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic send_str(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			push_word(s[i], last_at_end && (i == s.len() - 1), 1'b0);
	endtask

	task automatic send_bytes(logic [7:0] q[$], bit last_at_end);
		foreach (q[i])
			push_word(q[i], last_at_end && (i == q.size() - 1), 1'b0);
	endtask

	// well-formed path with random content, sometimes ended or broken on purpose
	task automatic send_random_path();
		logic [7:0] q[$];
		int         nseg;
		int         ntok;
		int         shape;
		q.push_back(SLASH);
		nseg = $urandom_range(0, 4);
		for (int s = 0; s <= nseg; s++) begin
			if (s > 0)
				q.push_back(SLASH);
			ntok = $urandom_range(0, 5);
			for (int t = 0; t < ntok; t++) begin
				if ($urandom_range(0, 3) == 0) begin
					q.push_back(PCT);
					q.push_back(random_hex());
					q.push_back(random_hex());
				end else begin
					q.push_back(random_pchar());
				end
			end
		end
		shape = $urandom_range(0, 11);
		case (shape)
			6: begin
				// stop byte then trailing bytes that are skipped
				q.push_back(random_stop());
				repeat ($urandom_range(0, 3)) q.push_back(random_byte());
				send_bytes(q, 1'b1);
			end
			7: begin
				// buffer ends by an empty word
				send_bytes(q, 1'b0);
				send_empty();
			end
			8: begin
				q[$urandom_range(0, q.size() - 1)] = random_byte();
				send_bytes(q, 1'b1);
			end
			9: begin
				// bad hex digit in an escape
				q.push_back(PCT);
				if ($urandom_range(0, 1))
					q.push_back(random_hex());
				q.push_back(random_non_hex());
				repeat ($urandom_range(0, 2)) q.push_back(random_byte());
				send_bytes(q, 1'b1);
			end
			10, 11: begin
				// escape cut off by the end of the buffer
				q.push_back(PCT);
				if ($urandom_range(0, 1))
					q.push_back(random_hex());
				if ($urandom_range(0, 1)) begin
					send_bytes(q, 1'b1);
				end else begin
					send_bytes(q, 1'b0);
					send_empty();
				end
			end
			default: send_bytes(q, 1'b1);
		endcase
	endtask

	// noise: random bytes, empty words and last flags in any order
	task automatic send_noise();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			if ($urandom_range(0, 1))
				push_word(SLASH, 1'b0, 1'b0);
			repeat ($urandom_range(0, 5)) push_word(random_byte(), 1'b0, 1'b0);
			push_word(random_byte(), 1'b1, 1'b0);
		end else if (r < 60) begin
			send_empty();
		end else if (r < 80) begin
			repeat ($urandom_range(1, 4)) push_word(random_byte(), 1'b0, 1'b0);
			send_empty();
		end else begin
			repeat ($urandom_range(1, 8))
				push_word(random_byte(), 1'($urandom_range(0, 1)),
					$urandom_range(0, 9) == 0);
		end
	endtask

	// watchdog on cycles with no accepted word on either side
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("tb_top failed");
		$finish;
	end

	// stimulus and verdict
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed corner paths
		send_str("/", 1'b1);
		send_empty();
		send_str("a", 1'b1);
		send_str("/a/", 1'b1);
		send_str("/%4", 1'b1);
		send_str("/%zq", 1'b1);
		send_str("/%4g", 1'b1);
		send_str("/b", 1'b0);
		push_word(8'hff, 1'b0, 1'b0);
		send_str("x", 1'b1);
		send_str("/a", 1'b0);
		send_empty();
		send_str("/%", 1'b0);
		send_empty();
		send_str("a", 1'b0);
		send_empty();

		// random paths, mostly well formed
		words_sent = 0;
		while (words_sent < RANDOM_WORDS) begin
			quiet = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 99) < 75)
				send_random_path();
			else
				send_noise();
		end
		quiet = 1'b0;
		push <= 1'b0;

		// drain, then allow for words still in flight
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

[uri_absolute_path_parser.f]
+incdir+src
src/upa_pkg.sv
src/upa_front.sv
src/upa_back.sv
src/uri_absolute_path_parser.sv
dv/path_checker.sv
dv/tb_top.sv
